// ===== rtl/core/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator package
// Shared widths, codes, divider interface types and the block count clamp.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int KIND_W    = 2;
  localparam int BYTES_W   = 29;
  localparam int OFF_W     = 40;
  localparam int CNT_W     = 13;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 40;
  localparam int DIV_CNT_W = 6;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALIGN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic [BYTES_W-1:0] BB_RESET  = 29'd65536;
  localparam logic [CNT_W-1:0]   BIU_RESET = 13'd4096;

  typedef struct packed {
    logic               start;
    logic [OFF_W-1:0]   dividend;
    logic [BYTES_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [OFF_W-1:0]   quotient;
    logic [BYTES_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [31:0] clamp_count(input logic [CNT_W-1:0] biu,
                                              input logic [31:0] maxb);
    logic [31:0] v;
    v = 32'(biu);
    if (v == 32'd0) begin
      return 32'd1;
    end
    if (v > maxb) begin
      return maxb;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/fbpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool serial divider
// Restoring divider, one quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fbpa_pkg::div_req_t req,
  output fbpa_pkg::div_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [fbpa_pkg::DIV_CNT_W-1:0]  step_r;
  logic [fbpa_pkg::OFF_W-1:0]      dvd_r;
  logic [fbpa_pkg::BYTES_W-1:0]    rem_r;
  logic [fbpa_pkg::BYTES_W-1:0]    dvs_r;

  logic [fbpa_pkg::BYTES_W:0]      trial;
  logic                            ge;

  assign trial = {rem_r, dvd_r[fbpa_pkg::OFF_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[fbpa_pkg::OFF_W-2:0], ge};
      rem_r <= ge ? fbpa_pkg::BYTES_W'(trial - {1'b0, dvs_r})
                  : trial[fbpa_pkg::BYTES_W-1:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/core/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Free list of equal blocks kept in a link memory with a fill watermark.
// ----------------------------------------------------------------------------
// Sequence: an allocate without alignment steps through S_PREP, S_CHECK and S_WRITE;
// allocate with alignment and free also wait in S_DIV on the 40-step serial divider.
// Throughput: one item at a time; the next start is taken the cycle out_valid shows.
// A free of a never-touched block above the watermark first fills each entry up to it.
// Reset: pool restarts with all blocks free at once; link memory needs no clearing.
// Results cannot be stalled: out_valid is a one-cycle strobe.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fbpa_pkg::KIND_W-1:0]       in_kind,
  input  logic [fbpa_pkg::BYTES_W-1:0]      in_request_bytes,
  input  logic [fbpa_pkg::BYTES_W-1:0]      in_align_bytes,
  input  logic [fbpa_pkg::OFF_W-1:0]        in_release_offset,
  input  logic [fbpa_pkg::BYTES_W-1:0]      in_release_padding,
  output logic                              out_valid,
  output logic [fbpa_pkg::STATUS_W-1:0]     out_status,
  output logic [fbpa_pkg::OFF_W-1:0]        out_block_offset,
  output logic [fbpa_pkg::CNT_W-1:0]        out_free_left,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::BYTES_W-1:0]      cfg_data
);

  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int PW = LW + fbpa_pkg::BYTES_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_FCHK  = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [fbpa_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [fbpa_pkg::BYTES_W-1:0]    req_r, req_nxt;
  logic [fbpa_pkg::BYTES_W-1:0]    align_r, align_nxt;
  logic [fbpa_pkg::OFF_W-1:0]      roff_r, roff_nxt;
  logic [fbpa_pkg::BYTES_W-1:0]    rpad_r, rpad_nxt;
  logic [fbpa_pkg::BYTES_W-1:0]    block_bytes_r, block_bytes_nxt;
  logic [fbpa_pkg::CNT_W-1:0]      blocks_in_use_r, blocks_in_use_nxt;
  logic [LW-1:0]                   head_r, head_nxt;
  logic [LW-1:0]                   free_count_r, free_count_nxt;
  logic [LW-1:0]                   wm_r, wm_nxt;
  logic [PW-1:0]                   mul_r, mul_nxt;
  logic [LW-1:0]                   wr_idx_r, wr_idx_nxt;
  logic [LW-1:0]                   wr_val_r, wr_val_nxt;
  logic [LW-1:0]                   rd_addr_r, rd_addr_nxt;
  logic [LW-1:0]                   rd_data_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [fbpa_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [fbpa_pkg::OFF_W-1:0]      out_offset_r, out_offset_nxt;
  logic [fbpa_pkg::CNT_W-1:0]      out_free_left_r, out_free_left_nxt;

  logic [LW-1:0]                   link_mem [MAX_BLOCKS];

  logic                            accept;
  logic                            cfg_fire;
  logic [fbpa_pkg::BYTES_W-1:0]    bb_eff;
  logic [LW-1:0]                   cnt_eff;
  logic [LW-1:0]                   cfg_cnt;
  logic [LW-1:0]                   link_val;
  logic [fbpa_pkg::OFF_W-1:0]      base;
  logic                            free_bad;
  logic                            alloc_go;
  logic                            fin;
  logic [fbpa_pkg::STATUS_W-1:0]   fin_status;
  logic                            mem_we;
  logic [IW-1:0]                   mem_wa;
  logic [LW-1:0]                   mem_wd;
  logic                            rd_en;
  fbpa_pkg::div_req_t              div_req;
  fbpa_pkg::div_rsp_t              div_rsp;

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = !busy && !start;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign bb_eff  = (block_bytes_r == '0) ? fbpa_pkg::BYTES_W'(1) : block_bytes_r;
  assign cnt_eff = LW'(fbpa_pkg::clamp_count(blocks_in_use_r, 32'(MAX_BLOCKS)));
  assign cfg_cnt = LW'(fbpa_pkg::clamp_count(
                     (cfg_index == fbpa_pkg::CFG_BLOCKS_IN_USE) ?
                       cfg_data[fbpa_pkg::CNT_W-1:0] : blocks_in_use_r,
                     32'(MAX_BLOCKS)));

  assign link_val = (rd_addr_r >= wm_r) ? LW'(rd_addr_r + 1'b1) : rd_data_r;
  assign base     = roff_r - fbpa_pkg::OFF_W'(rpad_r);
  assign free_bad = (free_count_r >= cnt_eff) ||
                    (fbpa_pkg::OFF_W'(rpad_r) > roff_r) ||
                    (PW'(roff_r) >= mul_r);

  fbpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt         = state_r;
    kind_nxt          = kind_r;
    req_nxt           = req_r;
    align_nxt         = align_r;
    roff_nxt          = roff_r;
    rpad_nxt          = rpad_r;
    block_bytes_nxt   = block_bytes_r;
    blocks_in_use_nxt = blocks_in_use_r;
    head_nxt          = head_r;
    free_count_nxt    = free_count_r;
    wm_nxt            = wm_r;
    mul_nxt           = mul_r;
    wr_idx_nxt        = wr_idx_r;
    wr_val_nxt        = wr_val_r;
    rd_addr_nxt       = rd_addr_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_offset_nxt    = out_offset_r;
    out_free_left_nxt = out_free_left_r;
    mem_we            = 1'b0;
    mem_wa            = wm_r[IW-1:0];
    mem_wd            = wr_val_r;
    rd_en             = 1'b0;
    div_req.start     = 1'b0;
    div_req.dividend  = base;
    div_req.divisor   = bb_eff;
    alloc_go          = 1'b0;
    fin               = 1'b0;
    fin_status        = fbpa_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          req_nxt   = in_request_bytes;
          align_nxt = in_align_bytes;
          roff_nxt  = in_release_offset;
          rpad_nxt  = in_release_padding;
          state_nxt = S_PREP;
        end
        if (cfg_fire) begin
          if (cfg_index == fbpa_pkg::CFG_BLOCK_BYTES) begin
            block_bytes_nxt = cfg_data;
          end
          if (cfg_index == fbpa_pkg::CFG_BLOCKS_IN_USE) begin
            blocks_in_use_nxt = cfg_data[fbpa_pkg::CNT_W-1:0];
          end
          if (cfg_index == fbpa_pkg::CFG_BLOCK_BYTES ||
              cfg_index == fbpa_pkg::CFG_BLOCKS_IN_USE) begin
            head_nxt       = '0;
            free_count_nxt = cfg_cnt;
            wm_nxt         = '0;
          end
        end
      end
      S_PREP: begin
        mul_nxt     = (kind_r == fbpa_pkg::KIND_FREE) ?
                        PW'(cnt_eff) * PW'(bb_eff) : PW'(head_r) * PW'(bb_eff);
        rd_en       = 1'b1;
        rd_addr_nxt = head_r;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        case (kind_r)
          fbpa_pkg::KIND_ALLOC: begin
            if (free_count_r == '0 || head_r >= cnt_eff) begin
              fin        = 1'b1;
              fin_status = fbpa_pkg::ST_EMPTY;
            end else if (req_r > bb_eff) begin
              fin        = 1'b1;
              fin_status = fbpa_pkg::ST_TOO_BIG;
            end else if (align_r != '0) begin
              div_req.start    = 1'b1;
              div_req.dividend = fbpa_pkg::OFF_W'(bb_eff);
              div_req.divisor  = align_r;
              state_nxt        = S_DIV;
            end else begin
              alloc_go = 1'b1;
            end
          end
          fbpa_pkg::KIND_FREE: begin
            if (free_bad) begin
              fin        = 1'b1;
              fin_status = fbpa_pkg::ST_BAD_FREE;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          fbpa_pkg::KIND_RESET: begin
            head_nxt       = '0;
            free_count_nxt = cnt_eff;
            wm_nxt         = '0;
            fin            = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (kind_r == fbpa_pkg::KIND_ALLOC) begin
            if (div_rsp.remainder != '0) begin
              fin        = 1'b1;
              fin_status = fbpa_pkg::ST_ALIGN;
            end else begin
              alloc_go = 1'b1;
            end
          end else if (div_rsp.remainder != '0 ||
                       div_rsp.quotient >= fbpa_pkg::OFF_W'(cnt_eff)) begin
            fin        = 1'b1;
            fin_status = fbpa_pkg::ST_BAD_FREE;
          end else begin
            rd_en       = 1'b1;
            rd_addr_nxt = LW'(div_rsp.quotient);
            state_nxt   = S_FCHK;
          end
        end
      end
      S_FCHK: begin
        if (link_val != cnt_eff) begin
          fin        = 1'b1;
          fin_status = fbpa_pkg::ST_BAD_FREE;
        end else begin
          wr_idx_nxt     = rd_addr_r;
          wr_val_nxt     = head_r;
          head_nxt       = rd_addr_r;
          free_count_nxt = free_count_r + 1'b1;
          state_nxt      = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        if (wm_r < wr_idx_r) begin
          mem_wa = wm_r[IW-1:0];
          mem_wd = LW'(wm_r + 1'b1);
          wm_nxt = LW'(wm_r + 1'b1);
        end else begin
          mem_wa = wr_idx_r[IW-1:0];
          mem_wd = wr_val_r;
          if (wr_idx_r == wm_r) begin
            wm_nxt = LW'(wm_r + 1'b1);
          end
          fin = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (alloc_go) begin
      head_nxt       = link_val;
      free_count_nxt = free_count_r - 1'b1;
      wr_idx_nxt     = head_r;
      wr_val_nxt     = cnt_eff;
      state_nxt      = S_WRITE;
    end

    if (fin) begin
      out_valid_nxt     = 1'b1;
      out_status_nxt    = fin_status;
      out_offset_nxt    = (fin_status == fbpa_pkg::ST_OK &&
                           kind_r == fbpa_pkg::KIND_ALLOC) ?
                            fbpa_pkg::OFF_W'(mul_r) : '0;
      out_free_left_nxt = fbpa_pkg::CNT_W'(free_count_nxt);
      state_nxt         = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      block_bytes_r   <= fbpa_pkg::BB_RESET;
      blocks_in_use_r <= fbpa_pkg::BIU_RESET;
      head_r          <= '0;
      free_count_r    <= LW'(fbpa_pkg::clamp_count(fbpa_pkg::BIU_RESET, 32'(MAX_BLOCKS)));
      wm_r            <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      block_bytes_r   <= block_bytes_nxt;
      blocks_in_use_r <= blocks_in_use_nxt;
      head_r          <= head_nxt;
      free_count_r    <= free_count_nxt;
      wm_r            <= wm_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    req_r           <= req_nxt;
    align_r         <= align_nxt;
    roff_r          <= roff_nxt;
    rpad_r          <= rpad_nxt;
    mul_r           <= mul_nxt;
    wr_idx_r        <= wr_idx_nxt;
    wr_val_r        <= wr_val_nxt;
    rd_addr_r       <= rd_addr_nxt;
    out_status_r    <= out_status_nxt;
    out_offset_r    <= out_offset_nxt;
    out_free_left_r <= out_free_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[rd_addr_nxt[IW-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_offset_r;
  assign out_free_left    = out_free_left_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= cnt_eff)
    else $error("free count above block count");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while item in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> wr_idx_r < cnt_eff)
    else $error("write target outside pool");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider result with no waiting item");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != fbpa_pkg::ST_OK |-> out_offset_r == '0)
    else $error("nonzero offset on failed item");

endmodule
